// ===== sv/bgd_pkg.sv =====
package bgd_pkg;

  // slots that can be enabled at most
  localparam int unsigned MAX_ACTIVE = 8;

  // field widths
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned CODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned WIN_W     = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_MASKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_WIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTI_CNT   = 3'd4;

  // register reset values and the multi-press count default
  localparam logic [WIN_W-1:0] PRESS_WIN_RST  = 16'd300;
  localparam logic [WIN_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [CNT_W-1:0] MULTI_CNT_RST  = 4'd3;
  localparam logic [CNT_W-1:0] MULTI_CNT_DEF  = 4'd3;

  // click count values of note
  localparam logic [CNT_W-1:0] CNT_SAT    = 4'd15;
  localparam logic [CNT_W-1:0] CNT_DOUBLE = 4'd2;

  // request types
  typedef enum logic [REQ_W-1:0] {
    OP_RISE = 2'd0,
    OP_FALL = 2'd1,
    OP_TICK = 2'd2,
    OP_SCAN = 2'd3
  } op_e;

  // event codes
  typedef enum logic [CODE_W-1:0] {
    EV_PRESS  = 2'd0,
    EV_LONG   = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_MULTI  = 2'd3
  } ev_e;

  // per-slot mode
  typedef enum logic [1:0] {
    MODE_RELEASED = 2'd0,
    MODE_PRESSED  = 2'd1,
    MODE_LONG     = 2'd2,
    MODE_MULTI    = 2'd3
  } slot_mode_e;

  // classified command passed from front to back
  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

endpackage

// ===== sv/bgd_if.sv =====
interface req_if import bgd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, output req_type, output slot, input ready);
  modport sink   (input valid, input req_type, input slot, output ready);
endinterface

interface evt_if import bgd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] event_slot;
  logic [CODE_W-1:0] event_code;
  logic              last;

  modport source (output valid, output event_slot, output event_code, output last,
                  input ready);
  modport sink   (input valid, input event_slot, input event_code, input last,
                  output ready);
endinterface

interface cfg_if import bgd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== sv/button_gesture_detector.sv =====
// Button gesture detector: tracks up to eight enabled button slots and turns rising
// edges, falling edges, millisecond ticks and scan requests into press, long-press,
// double-press and multi-press events, each gated by the slot's event mask. Requests
// enter a two-entry command queue, so the input side keeps taking requests while the
// back end works or waits on the event channel. The back end runs one request at a
// time: an edge or a tick passes through fetch, execute and finish, a scan visits
// each slot in two steps (long/multi check, then click window expiry), and a stall
// on the event channel holds either. The final event of a request carries last; a
// request whose events are all masked produces no transfer. Configuration writes are
// taken in any cycle and are meant to be issued only while the block is idle.
module button_gesture_detector import bgd_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  req_if.sink   req,
  evt_if.source evt,
  cfg_if.sink   cfg
);

  logic q_ready;
  logic q_push;
  cmd_t q_cmd_in;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd_out;

  // request classification
  bgd_front u_front (
    .req       (req),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_cmd_o   (q_cmd_in)
  );

  // command queue between front and back
  bgd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd_out)
  );

  // slot state, sequencer and event output
  bgd_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd_out),
    .cmd_pop_o   (q_pop),
    .cfg         (cfg),
    .evt         (evt)
  );

endmodule

// ===== sv/bgd_front.sv =====
module bgd_front import bgd_pkg::*; (
  req_if.sink  req,
  input  logic q_ready_i,
  output logic q_push_o,
  output cmd_t q_cmd_o
);

  // accept whenever the queue has room
  assign req.ready = q_ready_i;
  assign q_push_o  = req.valid && q_ready_i;

  // classify the request type
  always_comb begin
    q_cmd_o.slot = req.slot;
    case (req.req_type)
      OP_RISE: q_cmd_o.op = OP_RISE;
      OP_FALL: q_cmd_o.op = OP_FALL;
      OP_TICK: q_cmd_o.op = OP_TICK;
      default: q_cmd_o.op = OP_SCAN;
    endcase
  end

endmodule

// ===== sv/bgd_fifo.sv =====
module bgd_fifo import bgd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== sv/bgd_back.sv =====
module bgd_back import bgd_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  cfg_if.sink  cfg,
  evt_if.source evt
);

  localparam int unsigned ActSlots = (NUM_SLOTS < MAX_ACTIVE) ? NUM_SLOTS : MAX_ACTIVE;
  localparam int unsigned IdxW     = (ActSlots > 1) ? $clog2(ActSlots) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ActSlots - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } st_e;

  st_e  st_q, st_d;
  cmd_t cmd_q;
  logic [IdxW-1:0] idx_q;
  logic            phase_q;
  slot_mode_e      scan_mode_q;

  // configuration registers
  logic [MAX_ACTIVE-1:0] slot_en_q;
  logic [31:0]           ev_mask_q;
  logic [WIN_W-1:0]      press_win_q;
  logic [WIN_W-1:0]      long_ms_q;
  logic [CNT_W-1:0]      multi_q;

  // per-slot state
  slot_mode_e         mode_q   [ActSlots];
  logic [CNT_W-1:0]   cnt_q    [ActSlots];
  logic [STAMP_W-1:0] cstamp_q [ActSlots];
  logic [STAMP_W-1:0] hstamp_q [ActSlots];
  logic [STAMP_W-1:0] now_q;

  // pending event and output stage
  logic              pend_valid_q;
  logic [SLOT_W-1:0] pend_slot_q;
  ev_e               pend_code_q;
  logic              out_valid_q;
  logic [SLOT_W-1:0] out_slot_q;
  ev_e               out_code_q;
  logic              out_last_q;

  logic              cfg_wr;
  logic [MAX_ACTIVE-1:0] en_rising;
  logic [SLOT_W-1:0] cur_slot;
  logic [IdxW-1:0]   ai;
  logic              cur_active;
  slot_mode_e        cur_mode;
  logic [CNT_W-1:0]  cur_cnt;
  logic [STAMP_W-1:0] sel_stamp;
  logic [WIN_W-1:0]  sel_limit;
  logic [STAMP_W-1:0] elapsed;
  logic              timeout;
  logic [CNT_W-1:0]  target;
  logic              want_ev;
  ev_e               ev_code;
  logic              ev_fire;
  logic              out_free;
  logic              stall;
  logic              step_go;
  logic              load_mid;
  logic              load_end;
  logic              wr_mode, wr_cnt, wr_stamps, wr_cstamp;
  slot_mode_e        nxt_mode;
  logic [CNT_W-1:0]  nxt_cnt;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid;
  assign en_rising = cfg.wdata[MAX_ACTIVE-1:0] & ~slot_en_q;

  // slot under work and its state
  assign cur_slot   = (cmd_q.op == OP_SCAN) ? SLOT_W'(idx_q) : cmd_q.slot;
  assign ai         = cur_slot[IdxW-1:0];
  assign cur_active = (32'(cur_slot) < ActSlots) && slot_en_q[cur_slot];
  assign cur_mode   = mode_q[ai];
  assign cur_cnt    = cnt_q[ai];

  // shared timeout compare: hold stamp in the first scan step, click stamp otherwise
  always_comb begin
    if (cmd_q.op == OP_SCAN && !phase_q) begin
      sel_stamp = hstamp_q[ai];
      sel_limit = long_ms_q;
    end else begin
      sel_stamp = cstamp_q[ai];
      sel_limit = press_win_q;
    end
  end
  assign elapsed = now_q - sel_stamp;
  assign timeout = elapsed > {16'd0, sel_limit};
  assign target  = (multi_q == '0) ? MULTI_CNT_DEF : multi_q;

  // per-step slot update and event request
  always_comb begin
    want_ev   = 1'b0;
    ev_code   = EV_PRESS;
    wr_mode   = 1'b0;
    wr_cnt    = 1'b0;
    wr_stamps = 1'b0;
    wr_cstamp = 1'b0;
    nxt_mode  = cur_mode;
    nxt_cnt   = cur_cnt;
    if (cur_active) begin
      case (cmd_q.op)
        OP_RISE: begin
          if (cur_mode == MODE_RELEASED || cur_mode == MODE_MULTI) begin
            wr_stamps = 1'b1;
            wr_mode   = 1'b1;
            nxt_mode  = MODE_PRESSED;
            if (cur_cnt == '0) begin
              want_ev = 1'b1;
              ev_code = EV_PRESS;
            end
          end
        end
        OP_FALL: begin
          if (cur_mode == MODE_PRESSED || cur_mode == MODE_LONG) begin
            if (!timeout) begin
              wr_cstamp = 1'b1;
              if (cur_cnt != CNT_SAT) begin
                wr_cnt  = 1'b1;
                nxt_cnt = cur_cnt + 4'd1;
              end
            end
            wr_mode  = 1'b1;
            nxt_mode = MODE_RELEASED;
          end
        end
        OP_SCAN: begin
          if (!phase_q) begin
            // long press and multi press checks
            case (cur_mode)
              MODE_PRESSED: begin
                if (timeout && cur_cnt == '0) begin
                  want_ev  = 1'b1;
                  ev_code  = EV_LONG;
                  wr_mode  = 1'b1;
                  nxt_mode = MODE_LONG;
                end
              end
              MODE_RELEASED: begin
                if (cur_cnt == target) begin
                  want_ev  = 1'b1;
                  ev_code  = EV_MULTI;
                  wr_mode  = 1'b1;
                  nxt_mode = MODE_MULTI;
                end
              end
              default: ;
            endcase
          end else begin
            // click window expiry, by the mode seen in the first step
            case (scan_mode_q)
              MODE_PRESSED, MODE_MULTI: begin
                if (timeout) begin
                  wr_cnt  = 1'b1;
                  nxt_cnt = '0;
                end
              end
              MODE_RELEASED: begin
                if (timeout) begin
                  if (cur_cnt == CNT_DOUBLE) begin
                    want_ev = 1'b1;
                    ev_code = EV_DOUBLE;
                  end
                  wr_cnt  = 1'b1;
                  nxt_cnt = '0;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // event gating and handshake with the output stage
  assign ev_fire   = want_ev && ev_mask_q[{cur_slot, ev_code}];
  assign out_free  = !out_valid_q || evt.ready;
  assign stall     = ev_fire && pend_valid_q && !out_free;
  assign step_go   = (st_q == ST_RUN) && !stall;
  assign load_mid  = step_go && ev_fire && pend_valid_q;
  assign load_end  = (st_q == ST_DONE) && pend_valid_q && out_free;
  assign cmd_pop_o = (st_q == ST_IDLE) && cmd_valid_i;

  // sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          st_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_go) begin
          if (cmd_q.op != OP_SCAN) begin
            st_d = ST_DONE;
          end else if (phase_q && idx_q == LastIdx) begin
            st_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!pend_valid_q || out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      idx_q       <= '0;
      phase_q     <= 1'b0;
      scan_mode_q <= MODE_RELEASED;
      now_q       <= '0;
    end else begin
      st_q <= st_d;
      if (cmd_pop_o) begin
        idx_q   <= '0;
        phase_q <= 1'b0;
      end else if (step_go && cmd_q.op == OP_SCAN) begin
        phase_q <= ~phase_q;
        if (!phase_q) begin
          scan_mode_q <= cur_mode;
        end else if (idx_q != LastIdx) begin
          idx_q <= idx_q + IdxW'(1);
        end
      end
      if (step_go && cmd_q.op == OP_TICK) begin
        now_q <= now_q + 32'd1;
      end
    end
  end

  // command latch
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_en_q   <= '0;
      ev_mask_q   <= '0;
      press_win_q <= PRESS_WIN_RST;
      long_ms_q   <= LONG_PRESS_RST;
      multi_q     <= MULTI_CNT_RST;
    end else if (cfg_wr) begin
      case (cfg.index)
        CFG_SLOT_ENABLE: slot_en_q   <= cfg.wdata[MAX_ACTIVE-1:0];
        CFG_EVENT_MASKS: ev_mask_q   <= cfg.wdata;
        CFG_PRESS_WIN:   press_win_q <= cfg.wdata[WIN_W-1:0];
        CFG_LONG_PRESS:  long_ms_q   <= cfg.wdata[WIN_W-1:0];
        CFG_MULTI_CNT:   multi_q     <= cfg.wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // slot state: enabling a slot resets its mode and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ActSlots; i++) begin
        mode_q[i]   <= MODE_RELEASED;
        cnt_q[i]    <= '0;
        cstamp_q[i] <= '0;
        hstamp_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ActSlots; i++) begin
        if (cfg_wr && cfg.index == CFG_SLOT_ENABLE && en_rising[i]) begin
          mode_q[i] <= MODE_RELEASED;
          cnt_q[i]  <= '0;
        end else if (step_go && ai == IdxW'(i)) begin
          if (wr_mode) begin
            mode_q[i] <= nxt_mode;
          end
          if (wr_cnt) begin
            cnt_q[i] <= nxt_cnt;
          end
          if (wr_stamps || wr_cstamp) begin
            cstamp_q[i] <= now_q;
          end
          if (wr_stamps) begin
            hstamp_q[i] <= now_q;
          end
        end
      end
    end
  end

  // pending event and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (step_go && ev_fire) begin
        pend_valid_q <= 1'b1;
      end else if (load_end) begin
        pend_valid_q <= 1'b0;
      end
      if (load_mid || load_end) begin
        out_valid_q <= 1'b1;
      end else if (evt.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // event payload
  always_ff @(posedge clk_i) begin
    if (step_go && ev_fire) begin
      pend_slot_q <= cur_slot;
      pend_code_q <= ev_code;
    end
    if (load_mid || load_end) begin
      out_slot_q <= pend_slot_q;
      out_code_q <= pend_code_q;
      out_last_q <= load_end;
    end
  end

  assign evt.valid      = out_valid_q;
  assign evt.event_slot = out_slot_q;
  assign evt.event_code = out_code_q;
  assign evt.last       = out_last_q;

endmodule
